[design/rvid_pkg.sv]
// ----------------------------------------------------------------------------
// rvid_pkg
// Opcodes, exact system words, instruction bit positions and immediate
// formats for the RV32I decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ONEHOT_W = 40;
  localparam int unsigned REG_W    = 5;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ONEHOT_W-1:0] onehot_t;
  typedef logic [REG_W-1:0]    reg_idx_t;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;

  localparam logic [6:0] F7_ZERO = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam word_t WORD_ECALL  = 32'b00000000000000000000000001110011;
  localparam word_t WORD_EBREAK = 32'b00000000000100000000000001110011;

  // Bit position of each instruction in the one-hot vector.
  typedef enum logic [5:0] {
    I_LUI   = 6'd0,  I_AUIPC = 6'd1,  I_JAL   = 6'd2,  I_JALR  = 6'd3,
    I_BEQ   = 6'd4,  I_BNE   = 6'd5,  I_BLT   = 6'd6,  I_BGE   = 6'd7,
    I_BLTU  = 6'd8,  I_BGEU  = 6'd9,  I_LB    = 6'd10, I_LH    = 6'd11,
    I_LW    = 6'd12, I_LBU   = 6'd13, I_LHU   = 6'd14, I_SB    = 6'd15,
    I_SH    = 6'd16, I_SW    = 6'd17, I_ADDI  = 6'd18, I_SLTI  = 6'd19,
    I_SLTIU = 6'd20, I_XORI  = 6'd21, I_ORI   = 6'd22, I_ANDI  = 6'd23,
    I_SLLI  = 6'd24, I_SRLI  = 6'd25, I_SRAI  = 6'd26, I_ADD   = 6'd27,
    I_SUB   = 6'd28, I_SLL   = 6'd29, I_SLT   = 6'd30, I_SLTU  = 6'd31,
    I_XOR   = 6'd32, I_SRL   = 6'd33, I_SRA   = 6'd34, I_OR    = 6'd35,
    I_AND   = 6'd36, I_FENCE = 6'd37, I_ECALL = 6'd38, I_EBREAK = 6'd39
  } instr_idx_t;

  typedef enum logic [2:0] {
    FMT_NONE, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J
  } imm_fmt_t;

endpackage

[design/rvid_if.sv]
// ----------------------------------------------------------------------------
// rvid_in_if / rvid_out_if
// Valid/ready channels for instruction words and decoded results.
// ----------------------------------------------------------------------------
interface rvid_in_if;
  logic                 valid;
  logic                 ready;
  rvid_pkg::word_t      instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvid_out_if;
  logic                 valid;
  logic                 ready;
  rvid_pkg::onehot_t    instruction_onehot;
  rvid_pkg::reg_idx_t   source_reg_one;
  rvid_pkg::reg_idx_t   source_reg_two;
  rvid_pkg::reg_idx_t   dest_reg;
  rvid_pkg::reg_idx_t   shift_amount;
  logic signed [31:0]   immediate;

  modport source (output valid, output instruction_onehot, output source_reg_one,
                  output source_reg_two, output dest_reg, output shift_amount,
                  output immediate, input ready);
  modport sink   (input valid, input instruction_onehot, input source_reg_one,
                  input source_reg_two, input dest_reg, input shift_amount,
                  input immediate, output ready);
endinterface

[design/rvid_decode.sv]
// ----------------------------------------------------------------------------
// rvid_decode
// Opcode/funct decode into the one-hot instruction vector and the
// immediate format of the matched instruction.
// ----------------------------------------------------------------------------
module rvid_decode (
  input  rvid_pkg::word_t   word,
  output rvid_pkg::onehot_t onehot,
  output rvid_pkg::imm_fmt_t fmt
);
  import rvid_pkg::*;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic       hit;
  instr_idx_t idx;
  imm_fmt_t   fmt_raw;

  assign op = word[6:0];
  assign f3 = word[14:12];
  assign f7 = word[31:25];

  always_comb begin
    hit     = 1'b0;
    idx     = I_LUI;
    fmt_raw = FMT_NONE;
    unique case (op)
      OP_LUI: begin
        hit = 1'b1; idx = I_LUI; fmt_raw = FMT_U;
      end
      OP_AUIPC: begin
        hit = 1'b1; idx = I_AUIPC; fmt_raw = FMT_U;
      end
      OP_JAL: begin
        hit = 1'b1; idx = I_JAL; fmt_raw = FMT_J;
      end
      OP_JALR: begin
        hit = (f3 == 3'd0); idx = I_JALR; fmt_raw = FMT_I;
      end
      OP_BRANCH: begin
        fmt_raw = FMT_B;
        hit     = 1'b1;
        unique case (f3)
          3'd0: idx = I_BEQ;
          3'd1: idx = I_BNE;
          3'd4: idx = I_BLT;
          3'd5: idx = I_BGE;
          3'd6: idx = I_BLTU;
          3'd7: idx = I_BGEU;
          default: hit = 1'b0;
        endcase
      end
      OP_LOAD: begin
        fmt_raw = FMT_I;
        hit     = 1'b1;
        unique case (f3)
          3'd0: idx = I_LB;
          3'd1: idx = I_LH;
          3'd2: idx = I_LW;
          3'd4: idx = I_LBU;
          3'd5: idx = I_LHU;
          default: hit = 1'b0;
        endcase
      end
      OP_STORE: begin
        fmt_raw = FMT_S;
        hit     = 1'b1;
        unique case (f3)
          3'd0: idx = I_SB;
          3'd1: idx = I_SH;
          3'd2: idx = I_SW;
          default: hit = 1'b0;
        endcase
      end
      OP_IMM: begin
        fmt_raw = FMT_I;
        hit     = 1'b1;
        unique case (f3)
          3'd0: idx = I_ADDI;
          3'd1: begin
            idx = I_SLLI; hit = (f7 == F7_ZERO);
          end
          3'd2: idx = I_SLTI;
          3'd3: idx = I_SLTIU;
          3'd4: idx = I_XORI;
          3'd5: begin
            idx = (f7 == F7_ALT) ? I_SRAI : I_SRLI;
            hit = (f7 == F7_ZERO) || (f7 == F7_ALT);
          end
          3'd6: idx = I_ORI;
          3'd7: idx = I_ANDI;
          default: hit = 1'b0;
        endcase
      end
      OP_REG: begin
        if (f7 == F7_ZERO) begin
          hit = 1'b1;
          unique case (f3)
            3'd0: idx = I_ADD;
            3'd1: idx = I_SLL;
            3'd2: idx = I_SLT;
            3'd3: idx = I_SLTU;
            3'd4: idx = I_XOR;
            3'd5: idx = I_SRL;
            3'd6: idx = I_OR;
            3'd7: idx = I_AND;
            default: hit = 1'b0;
          endcase
        end else if (f7 == F7_ALT) begin
          hit = (f3 == 3'd0) || (f3 == 3'd5);
          idx = (f3 == 3'd5) ? I_SRA : I_SUB;
        end
      end
      OP_FENCE: begin
        hit = (f3 == 3'd0); idx = I_FENCE;
      end
      default: begin
        // system instructions match on the whole word only
        if (word == WORD_ECALL) begin
          hit = 1'b1; idx = I_ECALL;
        end else if (word == WORD_EBREAK) begin
          hit = 1'b1; idx = I_EBREAK;
        end
      end
    endcase
  end

  always_comb begin
    onehot = '0;
    if (hit) begin
      onehot[idx] = 1'b1;
    end
  end

  assign fmt = hit ? fmt_raw : FMT_NONE;

endmodule

[design/rvid_imm.sv]
// ----------------------------------------------------------------------------
// rvid_imm
// Immediate assembly for the I, S, B, U and J formats.
// ----------------------------------------------------------------------------
module rvid_imm (
  input  rvid_pkg::word_t    word,
  input  rvid_pkg::imm_fmt_t fmt,
  output logic signed [31:0] imm
);
  import rvid_pkg::*;

  always_comb begin
    unique case (fmt)
      FMT_I:   imm = {{20{word[31]}}, word[31:20]};
      FMT_S:   imm = {{20{word[31]}}, word[31:25], word[11:7]};
      FMT_B:   imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      FMT_U:   imm = {word[31:12], 12'b0};
      FMT_J:   imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      default: imm = '0;
    endcase
  end

endmodule

[design/rv32i_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Input register, then result register: a word captured at an input transfer is
// decoded into the result register once that register frees, then offered.
// Throughput: one word per cycle; the input stalls only while the result is
// held and the input register is full. Reset clears both valid flags only.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  rvid_in_if.sink     in_chan,
  rvid_out_if.source  out_chan
);
  import rvid_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  word_t              s1_word_r;
  logic               s2_valid_r, s2_valid_nxt;
  onehot_t            s2_onehot_r;
  logic signed [31:0] s2_imm_r;
  reg_idx_t           s2_rs1_r, s2_rs2_r, s2_rd_r, s2_shamt_r;

  logic               s2_load;
  logic               s1_load;
  onehot_t            dec_onehot;
  imm_fmt_t           dec_fmt;
  logic signed [31:0] dec_imm;

  rvid_decode u_decode (
    .word   (s1_word_r),
    .onehot (dec_onehot),
    .fmt    (dec_fmt)
  );

  rvid_imm u_imm (
    .word (s1_word_r),
    .fmt  (dec_fmt),
    .imm  (dec_imm)
  );

  // result register frees when empty or its contents transfer this cycle
  assign s2_load = !s2_valid_r || out_chan.ready;
  assign s1_load = !s1_valid_r || s2_load;

  assign in_chan.ready = s1_load;

  assign s1_valid_nxt = s1_load ? in_chan.valid : s1_valid_r;
  assign s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_chan.valid) begin
      s1_word_r <= in_chan.instruction_word;
    end
    if (s2_load && s1_valid_r) begin
      s2_onehot_r <= dec_onehot;
      s2_imm_r    <= dec_imm;
      s2_rs1_r    <= s1_word_r[19:15];
      s2_rs2_r    <= s1_word_r[24:20];
      s2_rd_r     <= s1_word_r[11:7];
      s2_shamt_r  <= s1_word_r[24:20];
    end
  end

  assign out_chan.valid              = s2_valid_r;
  assign out_chan.instruction_onehot = s2_onehot_r;
  assign out_chan.immediate          = s2_imm_r;
  assign out_chan.source_reg_one     = s2_rs1_r;
  assign out_chan.source_reg_two     = s2_rs2_r;
  assign out_chan.dest_reg           = s2_rd_r;
  assign out_chan.shift_amount       = s2_shamt_r;

  a_onehot_ok : assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $onehot0(s2_onehot_r))
    else $error("decoded vector has more than one bit set");

  a_unknown_no_imm : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && (s2_onehot_r == '0)) |-> (s2_imm_r == '0))
    else $error("unrecognized word carries a nonzero immediate");

  a_utype_low_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && (s2_onehot_r[I_LUI] || s2_onehot_r[I_AUIPC]))
      |-> (s2_imm_r[11:0] == 12'd0))
    else $error("U-type immediate has nonzero low bits");

  a_in_captured : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_valid_r)
    else $error("input transfer not held in the input register");

  a_stage_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_valid_r) |=> s2_valid_r)
    else $error("input register did not advance into an empty result register");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv32i_instruction_decoder. Legal encodings of all
// forty instructions, broken encodings, near-miss system words and raw
// random words go in. Random idle and stall bursts run on both channels.
// Every result is checked against a local decode of the accepted word.
// ----------------------------------------------------------------------------
module testbench;
  import rvid_pkg::*;

  localparam int unsigned NUM_RANDOM = 1400;
  localparam int unsigned CALM_TAIL  = 150;
  localparam int unsigned TIMEOUT    = 2_000_000;

  // funct3 codes
  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [2:0] F3_BEQ  = 3'd0, F3_BNE = 3'd1, F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5, F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_BYTE = 3'd0, F3_HALF = 3'd1, F3_WORD = 3'd2;
  localparam logic [2:0] F3_BYTEU = 3'd4, F3_HALFU = 3'd5;
  localparam logic [2:0] F3_ADD  = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3, F3_XOR = 3'd4, F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BAD_LOAD = 3'd3, F3_BAD_BRANCH = 3'd2;

  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  typedef struct packed {
    onehot_t     onehot;
    reg_idx_t    rs1;
    reg_idx_t    rs2;
    reg_idx_t    rd;
    reg_idx_t    shamt;
    logic [31:0] imm;
  } decoded_t;

  class decode_scoreboard;
    decoded_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function decoded_t decode(word_t w);
      logic [6:0] op;
      logic [2:0] f3;
      logic [6:0] f7;
      bit         hit;
      instr_idx_t ins;
      imm_fmt_t   fmt;
      decoded_t   d;
      op  = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      hit = 1'b1;
      ins = I_LUI;
      fmt = FMT_NONE;
      case (op)
        OP_LUI:   begin ins = I_LUI;   fmt = FMT_U; end
        OP_AUIPC: begin ins = I_AUIPC; fmt = FMT_U; end
        OP_JAL:   begin ins = I_JAL;   fmt = FMT_J; end
        OP_JALR: begin
          ins = I_JALR;
          fmt = FMT_I;
          hit = (f3 == F3_ZERO);
        end
        OP_BRANCH: begin
          fmt = FMT_B;
          case (f3)
            F3_BEQ:  ins = I_BEQ;
            F3_BNE:  ins = I_BNE;
            F3_BLT:  ins = I_BLT;
            F3_BGE:  ins = I_BGE;
            F3_BLTU: ins = I_BLTU;
            F3_BGEU: ins = I_BGEU;
            default: hit = 1'b0;
          endcase
        end
        OP_LOAD: begin
          fmt = FMT_I;
          case (f3)
            F3_BYTE:  ins = I_LB;
            F3_HALF:  ins = I_LH;
            F3_WORD:  ins = I_LW;
            F3_BYTEU: ins = I_LBU;
            F3_HALFU: ins = I_LHU;
            default:  hit = 1'b0;
          endcase
        end
        OP_STORE: begin
          fmt = FMT_S;
          case (f3)
            F3_BYTE: ins = I_SB;
            F3_HALF: ins = I_SH;
            F3_WORD: ins = I_SW;
            default: hit = 1'b0;
          endcase
        end
        OP_IMM: begin
          fmt = FMT_I;
          case (f3)
            F3_ADD:  ins = I_ADDI;
            F3_SLT:  ins = I_SLTI;
            F3_SLTU: ins = I_SLTIU;
            F3_XOR:  ins = I_XORI;
            F3_OR:   ins = I_ORI;
            F3_AND:  ins = I_ANDI;
            F3_SLL: begin
              ins = I_SLLI;
              hit = (f7 == F7_ZERO);
            end
            default: begin
              if (f7 == F7_ZERO) ins = I_SRLI;
              else if (f7 == F7_ALT) ins = I_SRAI;
              else hit = 1'b0;
            end
          endcase
        end
        OP_REG: begin
          if (f7 == F7_ZERO) begin
            case (f3)
              F3_ADD:  ins = I_ADD;
              F3_SLL:  ins = I_SLL;
              F3_SLT:  ins = I_SLT;
              F3_SLTU: ins = I_SLTU;
              F3_XOR:  ins = I_XOR;
              F3_SR:   ins = I_SRL;
              F3_OR:   ins = I_OR;
              default: ins = I_AND;
            endcase
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            ins = I_SUB;
          end else if (f7 == F7_ALT && f3 == F3_SR) begin
            ins = I_SRA;
          end else begin
            hit = 1'b0;
          end
        end
        OP_FENCE: begin
          ins = I_FENCE;
          hit = (f3 == F3_ZERO);
        end
        default: begin
          // system words only match in full
          if (w == WORD_ECALL) ins = I_ECALL;
          else if (w == WORD_EBREAK) ins = I_EBREAK;
          else hit = 1'b0;
        end
      endcase
      if (!hit) fmt = FMT_NONE;

      d.onehot = hit ? (onehot_t'(1) << ins) : '0;
      d.rs1    = w[19:15];
      d.rs2    = w[24:20];
      d.rd     = w[11:7];
      d.shamt  = w[24:20];
      case (fmt)
        FMT_I:   d.imm = {{20{w[31]}}, w[31:20]};
        FMT_S:   d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        FMT_B:   d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        FMT_U:   d.imm = {w[31:12], 12'b0};
        FMT_J:   d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        default: d.imm = '0;
      endcase
      return d;
    endfunction

    function void note_input(word_t w);
      expected_q.insert(expected_q.size(), decode(w));
    endfunction

    function void compare(string field, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        errors++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp, act);
      end
    endfunction

    function void check(decoded_t got);
      decoded_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no accepted word pending: onehot 0x%0h", got.onehot);
        return;
      end
      exp = expected_q.pop_front();
      compare("instruction_onehot", exp.onehot, got.onehot);
      compare("source_reg_one", exp.rs1, got.rs1);
      compare("source_reg_two", exp.rs2, got.rs2);
      compare("dest_reg", exp.rd, got.rd);
      compare("shift_amount", exp.shamt, got.shamt);
      compare("immediate", exp.imm, got.imm);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rvid_in_if  in_chan();
  rvid_out_if out_chan();

  rv32i_instruction_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  decode_scoreboard sb = new();
  // 0: no idling, else roughly one burst per idle_odds items/cycles
  int unsigned idle_odds = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Opcode and the fixed function fields of each instruction.
  function automatic void encoding_of(input instr_idx_t ins, output logic [6:0] op,
                                      output logic [2:0] f3, output logic [6:0] f7,
                                      output bit fix_f7);
    f3     = F3_ZERO;
    f7     = F7_ZERO;
    fix_f7 = 1'b0;
    case (ins)
      I_LUI:   op = OP_LUI;
      I_AUIPC: op = OP_AUIPC;
      I_JAL:   op = OP_JAL;
      I_JALR:  op = OP_JALR;
      I_BEQ:   begin op = OP_BRANCH; f3 = F3_BEQ;  end
      I_BNE:   begin op = OP_BRANCH; f3 = F3_BNE;  end
      I_BLT:   begin op = OP_BRANCH; f3 = F3_BLT;  end
      I_BGE:   begin op = OP_BRANCH; f3 = F3_BGE;  end
      I_BLTU:  begin op = OP_BRANCH; f3 = F3_BLTU; end
      I_BGEU:  begin op = OP_BRANCH; f3 = F3_BGEU; end
      I_LB:    begin op = OP_LOAD;  f3 = F3_BYTE;  end
      I_LH:    begin op = OP_LOAD;  f3 = F3_HALF;  end
      I_LW:    begin op = OP_LOAD;  f3 = F3_WORD;  end
      I_LBU:   begin op = OP_LOAD;  f3 = F3_BYTEU; end
      I_LHU:   begin op = OP_LOAD;  f3 = F3_HALFU; end
      I_SB:    begin op = OP_STORE; f3 = F3_BYTE;  end
      I_SH:    begin op = OP_STORE; f3 = F3_HALF;  end
      I_SW:    begin op = OP_STORE; f3 = F3_WORD;  end
      I_ADDI:  begin op = OP_IMM; f3 = F3_ADD;  end
      I_SLTI:  begin op = OP_IMM; f3 = F3_SLT;  end
      I_SLTIU: begin op = OP_IMM; f3 = F3_SLTU; end
      I_XORI:  begin op = OP_IMM; f3 = F3_XOR;  end
      I_ORI:   begin op = OP_IMM; f3 = F3_OR;   end
      I_ANDI:  begin op = OP_IMM; f3 = F3_AND;  end
      I_SLLI:  begin op = OP_IMM; f3 = F3_SLL; fix_f7 = 1'b1; end
      I_SRLI:  begin op = OP_IMM; f3 = F3_SR;  fix_f7 = 1'b1; end
      I_SRAI:  begin op = OP_IMM; f3 = F3_SR;  f7 = F7_ALT; fix_f7 = 1'b1; end
      I_ADD:   begin op = OP_REG; f3 = F3_ADD;  fix_f7 = 1'b1; end
      I_SUB:   begin op = OP_REG; f3 = F3_ADD;  f7 = F7_ALT; fix_f7 = 1'b1; end
      I_SLL:   begin op = OP_REG; f3 = F3_SLL;  fix_f7 = 1'b1; end
      I_SLT:   begin op = OP_REG; f3 = F3_SLT;  fix_f7 = 1'b1; end
      I_SLTU:  begin op = OP_REG; f3 = F3_SLTU; fix_f7 = 1'b1; end
      I_XOR:   begin op = OP_REG; f3 = F3_XOR;  fix_f7 = 1'b1; end
      I_SRL:   begin op = OP_REG; f3 = F3_SR;   fix_f7 = 1'b1; end
      I_SRA:   begin op = OP_REG; f3 = F3_SR;   f7 = F7_ALT; fix_f7 = 1'b1; end
      I_OR:    begin op = OP_REG; f3 = F3_OR;   fix_f7 = 1'b1; end
      I_AND:   begin op = OP_REG; f3 = F3_AND;  fix_f7 = 1'b1; end
      I_FENCE: op = OP_FENCE;
      default: op = OP_SYSTEM;
    endcase
  endfunction

  // Legal encoding of ins; fill supplies every free bit.
  function automatic word_t make_word(instr_idx_t ins, word_t fill);
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    bit         fix_f7;
    word_t      w;
    if (ins == I_ECALL) return WORD_ECALL;
    if (ins == I_EBREAK) return WORD_EBREAK;
    encoding_of(ins, op, f3, f7, fix_f7);
    w = fill;
    w[6:0] = op;
    if (op != OP_LUI && op != OP_AUIPC && op != OP_JAL) w[14:12] = f3;
    if (fix_f7) w[31:25] = f7;
    return w;
  endfunction

  function automatic word_t random_word();
    int unsigned pick;
    word_t       w;
    logic [6:0]  ops [10];
    ops  = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE,
             OP_IMM, OP_REG, OP_FENCE};
    pick = $urandom_range(0, 99);
    w    = $urandom;
    if (pick < 75) begin
      w = make_word(instr_idx_t'($urandom_range(0, ONEHOT_W - 1)), w);
    end else if (pick < 87) begin
      // known opcode, random function fields: many illegal combinations
      w[6:0] = ops[$urandom_range(0, 9)];
      if ($urandom_range(0, 1)) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
    end else if (pick < 93) begin
      // system word with one bit off
      w = $urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK;
      w[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
    end
    return w;
  endfunction

  // Caller is at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(word_t w);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.instruction_word <= w;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_input(w);
    @(negedge clk);
  endtask

  // Result side back-pressure.
  initial begin
    int unsigned stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left     = $urandom_range(1, 7) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check('{onehot: out_chan.instruction_onehot, rs1: out_chan.source_reg_one,
                 rs2: out_chan.source_reg_two, rd: out_chan.dest_reg,
                 shamt: out_chan.shift_amount, imm: out_chan.immediate});
    end
  end

  initial begin
    word_t w;
    int    k;
    rst_n                    = 1'b0;
    in_chan.valid            = 1'b0;
    in_chan.instruction_word = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every instruction, alternating all-ones, all-zero and random free bits
    idle_odds = 4;
    for (k = 0; k < ONEHOT_W; k++) begin
      w = (k % 3 == 0) ? '1 : (k % 3 == 1) ? '0 : word_t'($urandom);
      send_word(make_word(instr_idx_t'(k), w));
    end
    send_word('0);
    send_word('1);
    send_word(WORD_ECALL | 32'h0000_0080);
    send_word(WORD_EBREAK | 32'h8000_0000);
    send_word(make_word(I_SRAI, '1) ^ 32'h0200_0000);  // funct7 neither zero nor alt
    send_word(make_word(I_SLLI, '0) | 32'h4000_0000);
    send_word(make_word(I_SUB, '1) ^ {17'b0, F3_SLL ^ F3_ADD, 12'b0});
    send_word({make_word(I_JALR, '1)} & ~32'h0000_7000 | {17'b0, F3_SLL, 12'b0});
    send_word(make_word(I_FENCE, '0) | {17'b0, F3_AND, 12'b0});
    send_word(make_word(I_LW, '1) & ~32'h0000_7000 | {17'b0, F3_BAD_LOAD, 12'b0});
    send_word(make_word(I_BEQ, '0) | {17'b0, F3_BAD_BRANCH, 12'b0});
    send_word(make_word(I_SW, '1) & ~32'h0000_7000 | {17'b0, F3_BYTEU, 12'b0});

    for (k = 0; k < NUM_RANDOM; k++) begin
      if (k % 100 == 0) idle_odds = $urandom_range(0, 2) * 3;
      if (k >= NUM_RANDOM - CALM_TAIL) idle_odds = 0;
      send_word(random_word());
    end
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
